@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ rtl/sec_pkg.sv @@
// ----------------------------------------------------------------------------
// sec_pkg
// Types and codes for the serial EEPROM command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sec_pkg;

  localparam int FUNC_W  = 3;
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int STEP_W  = 4;
  localparam int CFG_IDX_W = 3;

  // Host and SPI item codes
  localparam logic [FUNC_W-1:0] FN_WSTAT_QUERY = 3'd0;
  localparam logic [FUNC_W-1:0] FN_RSTAT_QUERY = 3'd1;
  localparam logic [FUNC_W-1:0] FN_WREN        = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ_ADDR   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_FETCH       = 3'd4;
  localparam logic [FUNC_W-1:0] FN_WRITE_BYTE  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_TX_EMPTY    = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RX_BYTE     = 3'd7;

  // Sequence step codes
  localparam logic [STEP_W-1:0] ST_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] ST_RS1  = 4'd1;
  localparam logic [STEP_W-1:0] ST_RS2  = 4'd2;
  localparam logic [STEP_W-1:0] ST_RD1  = 4'd3;
  localparam logic [STEP_W-1:0] ST_RD2  = 4'd4;
  localparam logic [STEP_W-1:0] ST_RD3  = 4'd5;
  localparam logic [STEP_W-1:0] ST_RD4  = 4'd6;
  localparam logic [STEP_W-1:0] ST_WREN = 4'd7;
  localparam logic [STEP_W-1:0] ST_WR1  = 4'd8;
  localparam logic [STEP_W-1:0] ST_WR2  = 4'd9;
  localparam logic [STEP_W-1:0] ST_WR3  = 4'd10;
  localparam logic [STEP_W-1:0] ST_WR4  = 4'd11;

  // Status answers
  localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BUSY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_WP      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_READY   = 2'd3;

  // EEPROM status register bits
  localparam int SR_BUSY_BIT  = 0;
  localparam int SR_READY_BIT = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OP_RDSR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_WREN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_READ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_WRITE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 3'd4;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] RST_OP_RDSR  = 8'h05;
  localparam logic [BYTE_W-1:0] RST_OP_WREN  = 8'h06;
  localparam logic [BYTE_W-1:0] RST_OP_READ  = 8'h03;
  localparam logic [BYTE_W-1:0] RST_OP_WRITE = 8'h02;
  localparam logic [BYTE_W-1:0] RST_FILLER   = 8'h00;

  typedef struct packed {
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              chip_select_n;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] read_data;
    logic              idle;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/sec_cmd_if.sv @@
// ----------------------------------------------------------------------------
// sec_cmd_if
// Item channel into the sequencer: host commands and SPI events.
// ----------------------------------------------------------------------------
`default_nettype none

interface sec_cmd_if
  import sec_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] write_data;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, func, address, write_data, rx_byte, input ready);
  modport sink   (input valid, func, address, write_data, rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/sec_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sec_rsp_if
// Result channel out of the sequencer: send byte, chip select and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sec_rsp_if
  import sec_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [BYTE_W-1:0] send_byte;
  logic              chip_select_n;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] read_data;
  logic              idle;

  modport source (output valid, send_valid, send_byte, chip_select_n, status,
                  read_data, idle, input ready);
  modport sink   (input valid, send_valid, send_byte, chip_select_n, status,
                  read_data, idle, output ready);
endinterface

`default_nettype wire

@@ rtl/sec_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sec_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sec_cfg_if
  import sec_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/spi_eeprom_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// spi_eeprom_command_sequencer: serial EEPROM master command sequencer.
// The response is registered: it is captured in the response register, or in the skid entry while a response waits.
// Throughput: 1 item per cycle while cmd.ready is high, set by the single registered step update.
// A skid entry behind the response register takes one more transfer while
// a response waits, then input ready drops until the response drains.
// Reset (rst, synchronous): steps idle, chip select high, opcodes to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spi_eeprom_command_sequencer
  import sec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sec_cmd_if.sink   cmd,
  sec_rsp_if.source rsp,
  sec_cfg_if.sink   cfg
);

  // Configuration registers
  logic [BYTE_W-1:0] op_rdsr, op_wren, op_read, op_write, filler;

  // Sequencer state
  logic [STEP_W-1:0] tx_step, rx_step;
  logic [ADDR_W-1:0] target_address;
  logic [BYTE_W-1:0] data_byte;
  logic [STAT_W-1:0] write_status_held;
  logic              read_ready;
  logic              select_level;

  logic [STEP_W-1:0] tx_step_next, rx_step_next;
  logic [ADDR_W-1:0] target_address_next;
  logic [BYTE_W-1:0] data_byte_next;
  logic [STAT_W-1:0] write_status_held_next;
  logic              read_ready_next;
  logic              select_level_next;

  // Response buffer
  logic rsp_valid, skid_valid;
  rsp_t rsp_data, skid_data, result;

  logic both_idle, in_xfer, out_xfer;
  logic send_valid;
  logic [BYTE_W-1:0] send_byte;
  logic [STAT_W-1:0] status;

  assign cmd.ready = !skid_valid;
  assign cfg.ready = 1'b1;
  assign in_xfer   = cmd.valid && cmd.ready;
  assign out_xfer  = rsp.valid && rsp.ready;
  assign both_idle = (tx_step == ST_IDLE) && (rx_step == ST_IDLE);

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      op_rdsr  <= RST_OP_RDSR;
      op_wren  <= RST_OP_WREN;
      op_read  <= RST_OP_READ;
      op_write <= RST_OP_WRITE;
      filler   <= RST_FILLER;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_OP_RDSR:  op_rdsr  <= cfg.data;
        CFG_OP_WREN:  op_wren  <= cfg.data;
        CFG_OP_READ:  op_read  <= cfg.data;
        CFG_OP_WRITE: op_write <= cfg.data;
        CFG_FILLER:   filler   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Decode one item against the current state
  always_comb begin
    tx_step_next           = tx_step;
    rx_step_next           = rx_step;
    target_address_next    = target_address;
    data_byte_next         = data_byte;
    write_status_held_next = write_status_held;
    read_ready_next        = read_ready;
    select_level_next      = select_level;
    send_valid             = 1'b0;
    send_byte              = '0;
    status                 = STAT_UNKNOWN;

    unique case (cmd.func)
      FN_WSTAT_QUERY: begin
        if (write_status_held == STAT_UNKNOWN) begin
          if (both_idle) begin
            tx_step_next      = ST_RS1;
            rx_step_next      = ST_RS1;
            select_level_next = 1'b0;
            send_valid        = 1'b1;
            send_byte         = op_rdsr;
          end else begin
            status = STAT_BUSY;
          end
        end else begin
          status                 = write_status_held;
          write_status_held_next = STAT_UNKNOWN;
        end
      end
      FN_RSTAT_QUERY: begin
        if (read_ready) begin
          status = STAT_READY;
        end else if (!both_idle) begin
          status = STAT_BUSY;
        end
      end
      FN_WREN: begin
        if (both_idle) begin
          tx_step_next      = ST_WREN;
          rx_step_next      = ST_WREN;
          select_level_next = 1'b0;
          send_valid        = 1'b1;
          send_byte         = op_wren;
        end
      end
      FN_READ_ADDR: begin
        if (both_idle) begin
          target_address_next = cmd.address;
          tx_step_next        = ST_RD1;
          rx_step_next        = ST_RD1;
          select_level_next   = 1'b0;
          send_valid          = 1'b1;
          send_byte           = op_read;
        end
      end
      FN_FETCH: begin
        read_ready_next = 1'b0;
      end
      FN_WRITE_BYTE: begin
        if (both_idle) begin
          target_address_next = cmd.address;
          data_byte_next      = cmd.write_data;
          tx_step_next        = ST_WR1;
          rx_step_next        = ST_WR1;
          select_level_next   = 1'b0;
          send_valid          = 1'b1;
          send_byte           = op_write;
        end
      end
      FN_TX_EMPTY: begin
        unique case (tx_step)
          ST_RS1: begin
            send_valid = 1'b1; send_byte = filler; tx_step_next = ST_RS2;
          end
          ST_RD1: begin
            send_valid = 1'b1; send_byte = target_address[ADDR_W-1:BYTE_W];
            tx_step_next = ST_RD2;
          end
          ST_RD2: begin
            send_valid = 1'b1; send_byte = target_address[BYTE_W-1:0];
            tx_step_next = ST_RD3;
          end
          ST_RD3: begin
            send_valid = 1'b1; send_byte = filler; tx_step_next = ST_RD4;
          end
          ST_WR1: begin
            send_valid = 1'b1; send_byte = target_address[ADDR_W-1:BYTE_W];
            tx_step_next = ST_WR2;
          end
          ST_WR2: begin
            send_valid = 1'b1; send_byte = target_address[BYTE_W-1:0];
            tx_step_next = ST_WR3;
          end
          ST_WR3: begin
            send_valid = 1'b1; send_byte = data_byte; tx_step_next = ST_WR4;
          end
          ST_RS2, ST_RD4, ST_WREN, ST_WR4: tx_step_next = ST_IDLE;
          default: ;
        endcase
      end
      FN_RX_BYTE: begin
        unique case (rx_step)
          ST_RS1: rx_step_next = ST_RS2;
          ST_RS2: begin
            select_level_next = 1'b1;
            rx_step_next      = ST_IDLE;
            if (cmd.rx_byte[SR_BUSY_BIT]) begin
              write_status_held_next = STAT_BUSY;
            end else if (cmd.rx_byte[SR_READY_BIT]) begin
              write_status_held_next = STAT_READY;
            end else begin
              write_status_held_next = STAT_WP;
            end
          end
          ST_RD1: rx_step_next = ST_RD2;
          ST_RD2: rx_step_next = ST_RD3;
          ST_RD3: rx_step_next = ST_RD4;
          ST_RD4: begin
            data_byte_next    = cmd.rx_byte;
            select_level_next = 1'b1;
            read_ready_next   = 1'b1;
            rx_step_next      = ST_IDLE;
          end
          ST_WR1: rx_step_next = ST_WR2;
          ST_WR2: rx_step_next = ST_WR3;
          ST_WR3: rx_step_next = ST_WR4;
          ST_WREN, ST_WR4: begin
            select_level_next = 1'b1;
            rx_step_next      = ST_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Assemble the response from the updated state
  always_comb begin
    result.send_valid    = send_valid;
    result.send_byte     = send_byte;
    result.chip_select_n = select_level_next;
    result.status        = status;
    result.read_data     = data_byte_next;
    result.idle          = (tx_step_next == ST_IDLE) && (rx_step_next == ST_IDLE);
  end

  // Advance the sequencer state on each command transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_step           <= ST_IDLE;
      rx_step           <= ST_IDLE;
      target_address    <= '0;
      data_byte         <= '0;
      write_status_held <= STAT_UNKNOWN;
      read_ready        <= 1'b0;
      select_level      <= 1'b1;
    end else if (in_xfer) begin
      tx_step           <= tx_step_next;
      rx_step           <= rx_step_next;
      target_address    <= target_address_next;
      data_byte         <= data_byte_next;
      write_status_held <= write_status_held_next;
      read_ready        <= read_ready_next;
      select_level      <= select_level_next;
    end
  end

  // Response register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      if (rsp_valid) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      if (skid_valid) begin
        rsp_data <= skid_data;
      end else if (in_xfer) begin
        rsp_data <= result;
      end
    end else if (in_xfer) begin
      if (rsp_valid) begin
        skid_data <= result;
      end else begin
        rsp_data <= result;
      end
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.send_valid    = rsp_data.send_valid;
  assign rsp.send_byte     = rsp_data.send_byte;
  assign rsp.chip_select_n = rsp_data.chip_select_n;
  assign rsp.status        = rsp_data.status;
  assign rsp.read_data     = rsp_data.read_data;
  assign rsp.idle          = rsp_data.idle;

  // Checks
  `ASSERT_SAME(a_skid_behind_rsp, skid_valid, rsp_valid)
  `ASSERT_NEXT(a_rsp_after_xfer, in_xfer, rsp_valid)
  `ASSERT_NEXT(a_skid_holds, skid_valid && !rsp.ready, skid_valid && $stable(skid_data))
  `ASSERT_SAME(a_select_in_cmd, !select_level, rx_step != ST_IDLE)

endmodule

`default_nettype wire
